// File: rtl/core/lgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants of the Life generation stream: the payload
// structs of both channels, register indexes and default grid limits.
// ----------------------------------------------------------------------------
package lgs_pkg;

	// default grid limits and register reset value
	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DIM_RESET      = 64;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

	// front to back queue
	localparam int QUEUE_DEPTH = 4;

	// B3/S23 neighbour counts
	localparam logic [3:0] SURVIVE_LO  = 4'd2;
	localparam logic [3:0] BIRTH_COUNT = 4'd3;

	// emitted coordinate width
	localparam int COORD_W = 6;

	typedef struct packed {
		logic cell_alive;
		logic drain;
	} in_item_t;

	typedef struct packed {
		logic               next_alive;
		logic [COORD_W-1:0] out_row;
		logic [COORD_W-1:0] out_col;
		logic               last_of_frame;
	} out_item_t;

endpackage
`default_nettype wire

// File: rtl/core/lgs_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_fifo
// Short register queue between the classifying front and the cell back end.
// ----------------------------------------------------------------------------
module lgs_fifo #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	output logic                   full,
	input  wire logic              pop,
	output logic                   head_valid,
	output logic [DATA_W-1:0]      head_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/lgs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_front
// Accepts input items, holds the grid registers and the raster position,
// drops drains that do nothing and queues the rest with their row and column.
// ----------------------------------------------------------------------------
module lgs_front #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int COL_W      = $clog2(MAX_WIDTH),
	parameter int ROW_W      = $clog2(MAX_HEIGHT + 3),
	parameter int ENT_W      = 1 + ROW_W + COL_W
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              item_valid,
	input  wire lgs_pkg::in_item_t                 item,
	output logic                                   item_stall,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lgs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [lgs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              q_full,
	output logic                                   q_push,
	output logic [ENT_W-1:0]                       q_data,
	output logic [COL_W-1:0]                       wmax,
	output logic [ROW_W-1:0]                       hgt
);
	import lgs_pkg::*;

	localparam int RST_W = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
	localparam int RST_H = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

	logic [COL_W-1:0] wmax_q;
	logic [ROW_W-1:0] hgt_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic             accept;
	logic             cfg_we;
	logic             in_frame;
	logic             flushed;
	logic             proc;
	logic             cell_v;
	logic [ROW_W-1:0] r;
	logic [COL_W-1:0] c;
	logic [31:0]      val_ext;
	logic [31:0]      lim_w;
	logic [31:0]      lim_h;

	assign cfg_ready  = 1'b1;
	assign cfg_we     = cfg_valid && cfg_ready;
	assign item_stall = q_full;
	assign accept     = item_valid && !item_stall;
	assign wmax       = wmax_q;
	assign hgt        = hgt_q;

	// clamp written dimensions to 1..max
	always_comb begin
		val_ext = 32'(cfg_data);
		if (val_ext == 32'd0) begin
			lim_w = 32'd1;
			lim_h = 32'd1;
		end else begin
			lim_w = (val_ext > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : val_ext;
			lim_h = (val_ext > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : val_ext;
		end
	end

	// classify the item against the raster position
	always_comb begin
		in_frame = (row_q < hgt_q);
		// flush is over once row height+1, column 0 went through
		flushed  = (row_q > hgt_q + ROW_W'(1))
			|| ((row_q == hgt_q + ROW_W'(1)) && (col_q != '0));
		if (item.drain) begin
			proc   = !in_frame && !flushed;
			cell_v = 1'b0;
			r      = row_q;
			c      = col_q;
		end else begin
			proc   = 1'b1;
			cell_v = item.cell_alive;
			// a cell after the whole frame starts a new one
			r      = in_frame ? row_q : '0;
			c      = in_frame ? col_q : '0;
		end
	end

	assign q_push = accept && proc;
	assign q_data = {cell_v, r, c};

	// grid registers and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wmax_q <= COL_W'(RST_W - 1);
			hgt_q  <= ROW_W'(RST_H);
			col_q  <= '0;
			row_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_GRID_WIDTH) begin
				wmax_q <= COL_W'(lim_w - 32'd1);
				col_q  <= '0;
				row_q  <= '0;
			end else if (cfg_index == REG_GRID_HEIGHT) begin
				hgt_q <= ROW_W'(lim_h);
				col_q <= '0;
				row_q <= '0;
			end
		end else if (q_push) begin
			if (c == wmax_q) begin
				col_q <= '0;
				row_q <= r + ROW_W'(1);
			end else begin
				col_q <= c + COL_W'(1);
				row_q <= r;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/lgs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_back
// Line store, 3x3 window and B3/S23 rule. Pops one queued cell a cycle
// while the output register is free, reads its column of the two rows above,
// and emits the cell one row and one column behind into the output register.
// ----------------------------------------------------------------------------
module lgs_back #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int COL_W      = $clog2(MAX_WIDTH),
	parameter int ROW_W      = $clog2(MAX_HEIGHT + 3),
	parameter int ENT_W      = 1 + ROW_W + COL_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire logic [ENT_W-1:0] q_data,
	output logic                  q_pop,
	input  wire logic [COL_W-1:0] wmax,
	input  wire logic [ROW_W-1:0] hgt,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output lgs_pkg::out_item_t    res
);
	import lgs_pkg::*;

	// line store: bit 1 the row two above, bit 0 the row just above
	logic [1:0]       line_mem [MAX_WIDTH];

	logic             q_cell;
	logic [ROW_W-1:0] q_row;
	logic [COL_W-1:0] q_col;

	logic             valid_s1;
	logic             cell_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;
	logic [1:0]       rd_s1;
	logic [8:0]       window_q;
	logic             res_valid_q;
	out_item_t        res_q;

	logic             out_free;
	logic             fire;
	logic             take;
	logic             col0;
	logic             top;
	logic             mid;
	logic [8:0]       base;
	logic [8:0]       new_win;
	logic [8:0]       ewin;
	logic [8:0]       nb;
	logic [3:0]       n;
	logic             emit;
	logic             next_v;
	logic [ROW_W-1:0] erow;
	logic [COL_W-1:0] ecol;

	assign q_cell = q_data[ENT_W-1];
	assign q_row  = q_data[COL_W +: ROW_W];
	assign q_col  = q_data[COL_W-1:0];

	// stage handshake
	assign out_free = !res_valid_q || !res_stall;
	assign fire     = valid_s1 && out_free;
	assign take     = !valid_s1 || fire;
	assign q_pop    = q_valid && take;

	// window shift and neighbour count
	always_comb begin
		col0    = (col_s1 == '0);
		top     = (row_s1 >= ROW_W'(2)) ? rd_s1[1] : 1'b0;
		mid     = (row_s1 >= ROW_W'(1)) ? rd_s1[0] : 1'b0;
		base    = col0 ? 9'd0 : window_q;
		new_win = {cell_s1, mid, top, base[8:3]};
		// first column closes the previous row with a dead column on its right
		ewin    = col0 ? {3'b000, window_q[8:3]} : new_win;
		emit    = col0 ? (row_s1 >= ROW_W'(2)) : (row_s1 >= ROW_W'(1));
		erow    = col0 ? row_s1 - ROW_W'(2) : row_s1 - ROW_W'(1);
		ecol    = col0 ? wmax : col_s1 - COL_W'(1);
		nb      = ewin & 9'h1EF;
		n       = '0;
		for (int k = 0; k < 9; k++) begin
			n = n + 4'(nb[k]);
		end
		if (ewin[4]) begin
			next_v = (n == SURVIVE_LO) || (n == BIRTH_COUNT);
		end else begin
			next_v = (n == BIRTH_COUNT);
		end
	end

	// line store write and registered read with same-column bypass
	always_ff @(posedge clk) begin
		if (fire) begin
			line_mem[col_s1] <= {rd_s1[0], cell_s1};
		end
		if (q_pop) begin
			if (fire && (col_s1 == q_col)) begin
				rd_s1 <= {rd_s1[0], cell_s1};
			end else begin
				rd_s1 <= line_mem[q_col];
			end
			cell_s1 <= q_cell;
			row_s1  <= q_row;
			col_s1  <= q_col;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_q.next_alive    <= next_v;
			res_q.out_row       <= COORD_W'(erow);
			res_q.out_col       <= COORD_W'(ecol);
			res_q.last_of_frame <= (erow == hgt - ROW_W'(1)) && (ecol == wmax);
		end
	end

	// stage valid, window and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			window_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= q_valid;
			end
			if (fire) begin
				window_q <= new_win;
			end
			if (fire && emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

// File: rtl/core/life_generation_stream.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// life_generation_stream
// One generation of Life (B3/S23) on a bounded, non-wrapping grid.
//
// The current generation enters on the item channel, one cell per transfer
// in raster order. After the last cell, grid_width + 1 drain transfers flush
// the final row; other drains are dropped. A cell sent after the frame is
// complete starts the next frame. Each processed cell yields the next state
// of the cell one row and one column behind, with its row, column and a flag
// on the last cell of the grid, on the res channel.
// Throughput is one item per cycle unless the output stalls; the line store
// is read and written once per cycle at the cell's column. Items pass the
// queue to the stage register, which feeds the output register. Grid size
// is set on the cfg port (index 0 width, 1 height) by the user only while
// idle, which the block does not enforce; a write restarts the frame. Reset
// clears the position and sets a 64x64 grid; the line store is not cleared,
// rows above the grid read as dead. When res_stall is high the output holds
// and a short queue absorbs input until it fills, then item_stall rises.
// ----------------------------------------------------------------------------
module life_generation_stream #(
	parameter int MAX_WIDTH  = lgs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lgs_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           item_valid,
	output logic                                item_stall,
	input  wire lgs_pkg::in_item_t              item,
	output logic                                res_valid,
	input  wire logic                           res_stall,
	output lgs_pkg::out_item_t                  res,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lgs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lgs_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT + 3);
	localparam int ENT_W = 1 + ROW_W + COL_W;

	logic             q_full;
	logic             q_push;
	logic [ENT_W-1:0] q_in;
	logic             q_pop;
	logic             q_valid;
	logic [ENT_W-1:0] q_out;
	logic [COL_W-1:0] wmax;
	logic [ROW_W-1:0] hgt;

	// accept, classify and position
	lgs_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.COL_W      (COL_W),
		.ROW_W      (ROW_W),
		.ENT_W      (ENT_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_in),
		.wmax       (wmax),
		.hgt        (hgt)
	);

	// decoupling queue
	lgs_fifo #(
		.DATA_W (ENT_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (q_out)
	);

	// line store, window and rule
	lgs_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.COL_W      (COL_W),
		.ROW_W      (ROW_W),
		.ENT_W      (ENT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_out),
		.q_pop     (q_pop),
		.wmax      (wmax),
		.hgt       (hgt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
`default_nettype wire
